>>> rtl/assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

>>> rtl/dhc_pkg.sv
package dhc_pkg;

    // Depth word width actually used; inputs and registers are masked to it.
    localparam int DEPTH_BITS = 16;
    // Port widths fixed by the interface.
    localparam int PORT_BITS  = 16;
    // Channel width; the ramp scale is 2**CHAN_BITS - 1.
    localparam int CHAN_BITS  = 8;
    // Dividend width of the channel division: (2**CHAN_BITS - 1) * rem.
    localparam int NUM_W      = DEPTH_BITS + CHAN_BITS;
    // Clamp, two sector steps, scale, one stage per quotient bit, output.
    localparam int PIPE_LAT   = 5 + CHAN_BITS;

    typedef logic [DEPTH_BITS-1:0] t_depth;
    typedef logic [CHAN_BITS-1:0]  t_chan;
    typedef logic [NUM_W-1:0]      t_num;
    typedef logic [0:0]            t_cfg_idx;
    typedef logic [2:0]            t_sector;

    localparam t_cfg_idx CFG_DEPTH_MIN = 1'b0;
    localparam t_cfg_idx CFG_DEPTH_MAX = 1'b1;

    localparam t_depth DEPTH_MIN_RST = t_depth'(500);
    localparam t_depth DEPTH_MAX_RST = t_depth'(5800);

    // Hue sectors, near to far.
    localparam t_sector SEC_RED_YEL  = 3'd0;
    localparam t_sector SEC_YEL_GRN  = 3'd1;
    localparam t_sector SEC_GRN_CYN  = 3'd2;
    localparam t_sector SEC_CYN_BLU  = 3'd3;
    localparam t_sector SEC_BLUE     = 3'd4;

    localparam t_chan CH_FULL = '1;
    localparam t_chan CH_OFF  = '0;

    // Per-request flags that ride along the pipeline.
    typedef struct packed {
        logic    blk;   // zero depth: black
        logic    bad;   // empty or inverted ramp: red
        t_sector sec;
    } t_tag;

endpackage

>>> rtl/depth_hue_colorizer.sv
`include "assert_macros.svh"

// depth_hue_colorizer: maps one depth pixel to an RGB hue color. A request
// is taken on every clock where start is high (busy is always low: the
// pipeline takes one request per cycle with no gaps). The color appears
// on o_red/o_green/o_blue with o_valid high for exactly one cycle. Results
// leave in request order and the receiver cannot hold them off. The
// pipeline has one clamp stage, two sector compare/subtract stages, one
// x255 scale stage, eight restoring-division stages (one quotient bit
// each) and the output register. Depth 0 gives black; depth_max <=
// depth_min gives red for any nonzero depth. Write depth_min (index 0)
// and depth_max (index 1) only while no request is in flight; a write
// takes effect at once.
module depth_hue_colorizer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [15:0]         i_depth,
    input  logic                i_cfg_we,
    input  dhc_pkg::t_cfg_idx   i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    output logic                o_valid,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue
);
    import dhc_pkg::*;

    // ---------------- configuration ----------------
    t_depth r_depth_min;
    t_depth r_depth_max;
    t_depth range;
    logic   ramp_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_min <= DEPTH_MIN_RST;
            r_depth_max <= DEPTH_MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEPTH_MIN: r_depth_min <= i_cfg_data[DEPTH_BITS-1:0];
                CFG_DEPTH_MAX: r_depth_max <= i_cfg_data[DEPTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // The user must change the registers only while idle; the block does not enforce this. Every stage reads them live.
    assign range    = r_depth_max - r_depth_min;
    assign ramp_bad = (r_depth_max <= r_depth_min);

    // No backpressure anywhere: always ready.
    assign busy = 1'b0;

    // ---------------- stage 1: clamp, offset from min ----------------
    logic   r1_valid;
    t_tag   r1_tag;
    t_depth r1_off;
    t_depth d_in;
    t_depth d_clamp;
    t_tag   n1_tag;

    always_comb begin
        d_in = i_depth[DEPTH_BITS-1:0];
        if (d_in > r_depth_max) begin
            d_clamp = r_depth_max;
        end else if (d_in < r_depth_min) begin
            d_clamp = r_depth_min;
        end else begin
            d_clamp = d_in;
        end
        n1_tag.blk = (d_in == '0);
        n1_tag.bad = ramp_bad;
        n1_tag.sec = SEC_RED_YEL;
    end

    // ---------------- stage 2: x = 4*off, test against 2*range ----------------
    logic                  r2_valid;
    t_tag                  r2_tag;
    logic                  r2_top;     // off == range: far end, sector 4
    logic                  r2_hi;
    logic [DEPTH_BITS:0]   r2_x;
    logic [DEPTH_BITS+1:0] x4;
    logic [DEPTH_BITS+1:0] two_r;
    logic [DEPTH_BITS+1:0] x4_sub;
    logic                  n2_hi;
    logic [DEPTH_BITS:0]   n2_x;

    always_comb begin
        x4     = {r1_off, 2'b00};
        two_r  = {1'b0, range, 1'b0};
        x4_sub = x4 - two_r;
        n2_hi  = (x4 >= two_r);
        if (n2_hi) begin
            n2_x = x4_sub[DEPTH_BITS:0];
        end else begin
            n2_x = x4[DEPTH_BITS:0];
        end
    end

    // ---------------- stage 3: test against range, remainder ----------------
    logic                r3_valid;
    t_tag                r3_tag;
    t_depth              r3_rem;
    logic [DEPTH_BITS:0] x_sub;
    logic                n3_lo;
    t_depth              n3_rem;
    t_tag                n3_tag;

    always_comb begin
        x_sub  = r2_x - {1'b0, range};
        n3_lo  = (r2_x >= {1'b0, range});
        n3_rem = n3_lo ? x_sub[DEPTH_BITS-1:0] : r2_x[DEPTH_BITS-1:0];
        n3_tag = r2_tag;
        if (r2_top) begin
            n3_tag.sec = SEC_BLUE;
            n3_rem     = '0;
        end else begin
            n3_tag.sec = {1'b0, r2_hi, n3_lo};
        end
    end

    // ---------------- stage 4: numerator = 255 * rem ----------------
    logic r4_valid;
    t_tag r4_tag;
    t_num r4_num;
    t_num n4_num;

    assign n4_num = (t_num'(r3_rem) << CHAN_BITS) - t_num'(r3_rem);

    // ---------------- division: one quotient bit per stage ----------------
    logic  r_dv_valid [CHAN_BITS];
    t_tag  r_dv_tag   [CHAN_BITS];
    t_num  r_dv_part  [CHAN_BITS];
    t_chan r_dv_quo   [CHAN_BITS];
    t_num  n_dv_part  [CHAN_BITS];
    t_chan n_dv_quo   [CHAN_BITS];

    always_comb begin
        t_num  part;
        t_chan quo;
        t_num  dsh;
        for (int k = 0; k < CHAN_BITS; k++) begin
            part = (k == 0) ? r4_num : r_dv_part[(k == 0) ? 0 : k - 1];
            quo  = (k == 0) ? CH_OFF : r_dv_quo[(k == 0) ? 0 : k - 1];
            dsh  = t_num'(range) << (CHAN_BITS - 1 - k);
            if (part >= dsh) begin
                n_dv_part[k] = part - dsh;
                quo[CHAN_BITS-1-k] = 1'b1;
            end else begin
                n_dv_part[k] = part;
            end
            n_dv_quo[k] = quo;
        end
    end

    // ---------------- output select ----------------
    t_tag  last_tag;
    t_chan up;
    t_chan down;
    t_chan n_red;
    t_chan n_green;
    t_chan n_blue;

    always_comb begin
        last_tag = r_dv_tag[CHAN_BITS-1];
        up       = r_dv_quo[CHAN_BITS-1];
        // floor(255*(R-rem)/R) = 255 - ceil(255*rem/R)
        down     = CH_FULL - up - t_chan'(r_dv_part[CHAN_BITS-1] != '0);
        if (last_tag.blk) begin
            n_red = CH_OFF;  n_green = CH_OFF;  n_blue = CH_OFF;
        end else if (last_tag.bad) begin
            n_red = CH_FULL; n_green = CH_OFF;  n_blue = CH_OFF;
        end else begin
            case (last_tag.sec)
                SEC_RED_YEL: begin
                    n_red = CH_FULL; n_green = up;      n_blue = CH_OFF;
                end
                SEC_YEL_GRN: begin
                    n_red = down;    n_green = CH_FULL; n_blue = CH_OFF;
                end
                SEC_GRN_CYN: begin
                    n_red = CH_OFF;  n_green = CH_FULL; n_blue = up;
                end
                SEC_CYN_BLU: begin
                    n_red = CH_OFF;  n_green = down;    n_blue = CH_FULL;
                end
                default: begin
                    n_red = CH_OFF;  n_green = CH_OFF;  n_blue = CH_FULL;
                end
            endcase
        end
    end

    // ---------------- pipeline registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            for (int k = 0; k < CHAN_BITS; k++) begin
                r_dv_valid[k] <= 1'b0;
            end
            o_valid <= 1'b0;
        end else begin
            r1_valid <= start && !busy;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r_dv_valid[0] <= r4_valid;
            for (int k = 1; k < CHAN_BITS; k++) begin
                r_dv_valid[k] <= r_dv_valid[k-1];
            end
            o_valid <= r_dv_valid[CHAN_BITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r1_tag <= n1_tag;
        r1_off <= d_clamp - r_depth_min;
        r2_tag <= r1_tag;
        r2_top <= (r1_off == range);
        r2_hi  <= n2_hi;
        r2_x   <= n2_x;
        r3_tag <= n3_tag;
        r3_rem <= n3_rem;
        r4_tag <= r3_tag;
        r4_num <= n4_num;
        r_dv_tag[0] <= r4_tag;
        for (int k = 1; k < CHAN_BITS; k++) begin
            r_dv_tag[k] <= r_dv_tag[k-1];
        end
        for (int k = 0; k < CHAN_BITS; k++) begin
            r_dv_part[k] <= n_dv_part[k];
            r_dv_quo[k]  <= n_dv_quo[k];
        end
        o_red   <= n_red;
        o_green <= n_green;
        o_blue  <= n_blue;
    end

    // ---------------- assertions ----------------
    `ASSERT_IMPL(a_no_invented, i_clk, i_rst_n, o_valid, $past(start && !busy, PIPE_LAT))
    `ASSERT_IMPL(a_sector_ok, i_clk, i_rst_n, r3_valid && !r3_tag.bad, (r3_tag.sec <= SEC_BLUE) && (r3_rem < range))
    `ASSERT_NEXT(a_far_end, i_clk, i_rst_n, r3_valid && (r3_tag.sec == SEC_BLUE), r4_num == '0)
    `ASSERT_IMPL(a_div_rem, i_clk, i_rst_n, r_dv_valid[CHAN_BITS-1] && !r_dv_tag[CHAN_BITS-1].bad, r_dv_part[CHAN_BITS-1] < t_num'(range))

endmodule
